/* rtl/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants of the sparse set partition table
// Field widths, operation and status codes, sequencer states, defaults.
// ----------------------------------------------------------------------------
package ssp_pkg;

  // Default sizing
  localparam int unsigned RANGE_SIZE_DEF   = 64;
  localparam int unsigned NUM_SETS_DEF     = 8;
  localparam int unsigned SET_CAPACITY_DEF = 64;

  // Fixed field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned ELEM_W   = 6;
  localparam int unsigned SET_W    = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned CFG_W    = 4;

  // Sets reachable through a 3-bit set index
  localparam int unsigned SET_SPAN = 1 << SET_W;

  // Configuration port
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;
  localparam logic [CFG_W-1:0] SETS_IN_USE_RST = CFG_W'(8);

  typedef enum logic [0:0] {
    REG_SETS_IN_USE = 1'b0
  } reg_idx_e;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_DRAIN  = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_BAD_SET = 3'd1,
    ST_PRESENT = 3'd2,
    ST_FULL    = 3'd3,
    ST_ABSENT  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MOVE,
    S_RESP,
    S_DRAIN_SCAN,
    S_DRAIN_DATA
  } state_e;

endpackage

/* rtl/ssp_ram.sv */
// ----------------------------------------------------------------------------
// ssp_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ssp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sparse_set_partition_table.sv */
// ----------------------------------------------------------------------------
// sparse_set_partition_table_top: disjoint sets over a bounded universe
// Add, remove, query and drain on dense member arrays kept in RAM.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_stall_o) carries one operation per transfer:
//   func_i, element_i, set_index_i. Output channel (out_valid_o / out_stall_i)
//   carries result transfers; the final result of an operation has last_o set.
//   Add, remove and query give one result; drain gives one result per removed
//   element, or a single empty result when nothing was removed.
//   Sequence: add, query, a remove without a move and a drain with nothing to
//   remove pass through decode, then load their result in the response state
//   and return to idle to take the next operation; a remove that moves a
//   member adds a move state before the response. A drain steps from decode
//   to a scan state, which reads a member, then to a data state that loads it,
//   once per element; the scan state also steps over each empty set it meets.
//   One operation is in flight at a time; the element table
//   and member array are single-read RAMs that each access waits on.
//   The result sits in an output register; a stall on the output holds the
//   sequencer only when it has a new result to write there.
//   Reset empties every set at once (presence bits and set counts are flops)
//   and sets sets_in_use to 8. The APB port writes sets_in_use at byte 0;
//   write it only while no operation is in progress.
// ----------------------------------------------------------------------------
module sparse_set_partition_table_top #(
  parameter int unsigned RANGE_SIZE   = ssp_pkg::RANGE_SIZE_DEF,
  parameter int unsigned NUM_SETS     = ssp_pkg::NUM_SETS_DEF,
  parameter int unsigned SET_CAPACITY = ssp_pkg::SET_CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // operation channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ssp_pkg::FUNC_W-1:0]    func_i,
  input  logic [ssp_pkg::ELEM_W-1:0]    element_i,
  input  logic [ssp_pkg::SET_W-1:0]     set_index_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ssp_pkg::STATUS_W-1:0]  status_o,
  output logic                          found_o,
  output logic [ssp_pkg::SET_W-1:0]     owner_set_o,
  output logic [ssp_pkg::ELEM_W-1:0]    drained_element_o,
  output logic                          drained_valid_o,
  output logic                          last_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssp_pkg::APB_AW-1:0]    paddr,
  input  logic [ssp_pkg::APB_DW-1:0]    pwdata,
  output logic [ssp_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  import ssp_pkg::*;

  // Only sets 0..7 can ever receive members
  localparam int unsigned NUM_REACH = (NUM_SETS < SET_SPAN) ? NUM_SETS : SET_SPAN;
  localparam int unsigned CW        = (NUM_REACH > 1) ? $clog2(NUM_REACH) : 1;
  localparam int unsigned ET_AW     = $clog2(RANGE_SIZE);
  localparam int unsigned ET_W      = SET_W + POS_W;
  localparam int unsigned MW_DEPTH  = NUM_REACH * SET_CAPACITY;
  localparam int unsigned MW_AW     = (MW_DEPTH > 1) ? $clog2(MW_DEPTH) : 1;

  function automatic logic [MW_AW-1:0] mem_addr(input logic [SET_W-1:0] set,
                                                input logic [POS_W-1:0] pos);
    mem_addr = MW_AW'(set) * MW_AW'(SET_CAPACITY) + MW_AW'(pos);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] cfg_q;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_SETS_IN_USE);
  assign prdata  = reg_hit ? APB_DW'(cfg_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= SETS_IN_USE_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      cfg_q <= pwdata[CFG_W-1:0];
    end
  end

  // active sets, saturated to the reachable sets
  logic [CFG_W-1:0] n_eff;
  assign n_eff = (cfg_q > CFG_W'(NUM_REACH)) ? CFG_W'(NUM_REACH) : cfg_q;

  // --------------------------------------------------------------------------
  // State and memories
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [RANGE_SIZE-1:0] present_q, present_d;
  logic [CNT_W-1:0]      count_q [NUM_REACH];
  logic [CNT_W-1:0]      count_d [NUM_REACH];

  func_e             func_q;
  logic [ELEM_W-1:0] elem_q;
  logic [SET_W-1:0]  sidx_q;

  logic [SET_W-1:0]    own_q, own_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [SET_W-1:0]    set_q, set_d;
  logic [POS_W-1:0]    idx_q, idx_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic                res_found_q, res_found_d;
  logic [SET_W-1:0]    res_owner_q, res_owner_d;

  logic                out_valid_q;
  logic                out_load;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic                out_found_q, out_found_d;
  logic [SET_W-1:0]    out_owner_q, out_owner_d;
  logic [ELEM_W-1:0]   out_elem_q, out_elem_d;
  logic                out_dval_q, out_dval_d;
  logic                out_last_q, out_last_d;

  // element table: {owner, position}
  logic             et_we, et_re;
  logic [ET_AW-1:0] et_waddr, et_raddr;
  logic [ET_W-1:0]  et_wdata, et_rdata;

  // member array
  logic              mw_we, mw_re;
  logic [MW_AW-1:0]  mw_waddr, mw_raddr;
  logic [ELEM_W-1:0] mw_wdata, mw_rdata;

  ssp_ram #(
    .WIDTH(ET_W),
    .DEPTH(RANGE_SIZE)
  ) u_elem_tab (
    .clk_i  (clk_i),
    .we_i   (et_we),
    .waddr_i(et_waddr),
    .wdata_i(et_wdata),
    .re_i   (et_re),
    .raddr_i(et_raddr),
    .rdata_o(et_rdata)
  );

  ssp_ram #(
    .WIDTH(ELEM_W),
    .DEPTH(MW_DEPTH)
  ) u_members (
    .clk_i  (clk_i),
    .we_i   (mw_we),
    .waddr_i(mw_waddr),
    .wdata_i(mw_wdata),
    .re_i   (mw_re),
    .raddr_i(mw_raddr),
    .rdata_o(mw_rdata)
  );

  // --------------------------------------------------------------------------
  // Decode terms
  // --------------------------------------------------------------------------
  logic in_acc, out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  logic             elem_in_range, present_hit, sidx_ok, set_full;
  logic [ET_AW-1:0] eidx;
  logic [CNT_W-1:0] cnt_sidx;

  assign elem_in_range = ({1'b0, elem_q} < (ELEM_W + 1)'(RANGE_SIZE));
  assign eidx          = elem_q[ET_AW-1:0];
  assign present_hit   = elem_in_range && present_q[eidx];
  assign sidx_ok       = (CFG_W'(sidx_q) < n_eff);
  assign cnt_sidx      = sidx_ok ? count_q[sidx_q[CW-1:0]] : '0;
  assign set_full      = (cnt_sidx >= CNT_W'(SET_CAPACITY));

  logic [SET_W-1:0] own_rd;
  logic [POS_W-1:0] pos_rd;
  logic             own_ok, rm_consistent, rm_move;
  logic [CNT_W-1:0] cnt_own, rm_last;

  assign own_rd        = et_rdata[ET_W-1:POS_W];
  assign pos_rd        = et_rdata[POS_W-1:0];
  assign own_ok        = ((SET_W + 1)'(own_rd) < (SET_W + 1)'(NUM_REACH));
  assign cnt_own       = own_ok ? count_q[own_rd[CW-1:0]] : '0;
  assign rm_consistent = own_ok && (cnt_own != '0) && (CNT_W'(pos_rd) < cnt_own);
  assign rm_last       = cnt_own - CNT_W'(1);
  assign rm_move       = (CNT_W'(pos_rd) != rm_last);

  logic moved_in_range;
  assign moved_in_range = ({1'b0, mw_rdata} < (ELEM_W + 1)'(RANGE_SIZE));

  // drain walk
  logic [NUM_REACH-1:0] nonempty, from_start, after_cur;
  logic                 drain_any, rest_after, set_cur_ok, is_last_member;
  logic [CNT_W-1:0]     cnt_cur;

  always_comb begin
    for (int j = 0; j < NUM_REACH; j++) begin
      nonempty[j]   = (CFG_W'(j) < n_eff) && (count_q[j] != '0);
      from_start[j] = (SET_W'(j) >= sidx_q);
      after_cur[j]  = (SET_W'(j) > set_q);
    end
  end

  assign drain_any      = |(nonempty & from_start);
  assign rest_after     = |(nonempty & after_cur);
  assign set_cur_ok     = ((SET_W + 1)'(set_q) < (SET_W + 1)'(NUM_REACH));
  assign cnt_cur        = set_cur_ok ? count_q[set_q[CW-1:0]] : '0;
  assign is_last_member = (CNT_W'(idx_q) == cnt_cur - CNT_W'(1));

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_DECODE;
      end
      S_DECODE: begin
        priority if (func_q == FUNC_REMOVE && present_hit && rm_consistent && rm_move) begin
          state_d = S_MOVE;
        end else if (func_q == FUNC_DRAIN && drain_any) begin
          state_d = S_DRAIN_SCAN;
        end else begin
          state_d = S_RESP;
        end
      end
      S_MOVE: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      S_DRAIN_SCAN: begin
        if (cnt_cur != '0) state_d = S_DRAIN_DATA;
      end
      S_DRAIN_DATA: begin
        if (out_free) begin
          state_d = (is_last_member && !rest_after) ? S_IDLE : S_DRAIN_SCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: actions
  // --------------------------------------------------------------------------
  always_comb begin
    et_re    = 1'b0;
    et_raddr = element_i[ET_AW-1:0];
    et_we    = 1'b0;
    et_waddr = eidx;
    et_wdata = {sidx_q, cnt_sidx[POS_W-1:0]};
    mw_we    = 1'b0;
    mw_waddr = mem_addr(sidx_q, cnt_sidx[POS_W-1:0]);
    mw_wdata = elem_q;
    mw_re    = 1'b0;
    mw_raddr = mem_addr(set_q, idx_q);

    present_d    = present_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_owner_d  = res_owner_q;
    own_d        = own_q;
    pos_d        = pos_q;
    set_d        = set_q;
    idx_d        = idx_q;

    out_load     = 1'b0;
    out_status_d = res_status_q;
    out_found_d  = res_found_q;
    out_owner_d  = res_owner_q;
    out_elem_d   = '0;
    out_dval_d   = 1'b0;
    out_last_d   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        et_re = in_acc;
      end
      S_DECODE: begin
        res_found_d = 1'b0;
        res_owner_d = '0;
        unique case (func_q)
          FUNC_ADD: begin
            priority if (!elem_in_range) begin
              res_status_d = ST_ABSENT;
            end else if (!sidx_ok) begin
              res_status_d = ST_BAD_SET;
            end else if (present_hit) begin
              res_status_d = ST_PRESENT;
            end else if (set_full) begin
              res_status_d = ST_FULL;
            end else begin
              res_status_d                = ST_OK;
              mw_we                       = 1'b1;
              et_we                       = 1'b1;
              present_d[eidx]             = 1'b1;
              count_d[sidx_q[CW-1:0]]     = cnt_sidx + CNT_W'(1);
            end
          end
          FUNC_REMOVE: begin
            if (!present_hit) begin
              res_status_d = ST_ABSENT;
            end else begin
              res_status_d    = ST_OK;
              present_d[eidx] = 1'b0;
              if (rm_consistent) begin
                count_d[own_rd[CW-1:0]] = rm_last;
                own_d    = own_rd;
                pos_d    = pos_rd;
                // fetch the last member to fill the hole
                mw_raddr = mem_addr(own_rd, rm_last[POS_W-1:0]);
                mw_re    = rm_move;
              end
            end
          end
          FUNC_QUERY: begin
            if (present_hit) begin
              res_status_d = ST_OK;
              res_found_d  = 1'b1;
              res_owner_d  = own_rd;
            end else begin
              res_status_d = ST_ABSENT;
            end
          end
          FUNC_DRAIN: begin
            res_status_d = ST_OK;
            set_d        = sidx_q;
            idx_d        = '0;
          end
          default: res_status_d = ST_OK;
        endcase
      end
      S_MOVE: begin
        mw_we    = 1'b1;
        mw_waddr = mem_addr(own_q, pos_q);
        mw_wdata = mw_rdata;
        et_we    = moved_in_range;
        et_waddr = mw_rdata[ET_AW-1:0];
        et_wdata = {own_q, pos_q};
      end
      S_RESP: begin
        out_load = out_free;
      end
      S_DRAIN_SCAN: begin
        if (cnt_cur == '0) begin
          set_d = set_q + SET_W'(1);
        end else begin
          mw_re = 1'b1;
        end
      end
      S_DRAIN_DATA: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = ST_OK;
          out_found_d  = 1'b0;
          out_owner_d  = '0;
          out_elem_d   = mw_rdata;
          out_dval_d   = 1'b1;
          out_last_d   = is_last_member && !rest_after;
          if (moved_in_range) present_d[mw_rdata[ET_AW-1:0]] = 1'b0;
          if (is_last_member) begin
            count_d[set_q[CW-1:0]] = '0;
            set_d = set_q + SET_W'(1);
            idx_d = '0;
          end else begin
            idx_d = idx_q + POS_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      present_q   <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < NUM_REACH; j++) begin
        count_q[j] <= '0;
      end
    end else begin
      state_q   <= state_d;
      present_q <= present_d;
      count_q   <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_e'(func_i);
      elem_q <= element_i;
      sidx_q <= set_index_i;
    end
    own_q        <= own_d;
    pos_q        <= pos_d;
    set_q        <= set_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_owner_q  <= res_owner_d;
    if (out_load) begin
      out_status_q <= out_status_d;
      out_found_q  <= out_found_d;
      out_owner_q  <= out_owner_d;
      out_elem_q   <= out_elem_d;
      out_dval_q   <= out_dval_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign found_o           = out_found_q;
  assign owner_set_o       = out_owner_q;
  assign drained_element_o = out_elem_q;
  assign drained_valid_o   = out_dval_q;
  assign last_o            = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic [CNT_W:0] count_sum;

  always_comb begin
    count_sum = '0;
    for (int j = 0; j < NUM_REACH; j++) begin
      count_sum = count_sum + (CNT_W + 1)'(count_q[j]);
    end
  end

  // held elements and set counts agree whenever no operation is in progress
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> $countones(present_q) == int'(count_sum))
    else $error("presence bits disagree with set counts");

  a_drain_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drained_valid_o |-> status_o == ST_OK && !found_o)
    else $error("drained result carries query or error fields");

  // only drain produces more than one result per operation
  a_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> drained_valid_o)
    else $error("non-final result without a drained element");

endmodule

/* bench/ssp_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssp_result_checker: scoreboard for the sparse set partition table
// Watches the operation, result and APB channels, keeps its own copy of the
// set tables, predicts every result and compares each result transfer.
// ----------------------------------------------------------------------------
module ssp_result_checker #(
  parameter int unsigned RANGE_SIZE   = ssp_pkg::RANGE_SIZE_DEF,
  parameter int unsigned NUM_SETS     = ssp_pkg::NUM_SETS_DEF,
  parameter int unsigned SET_CAPACITY = ssp_pkg::SET_CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // operation channel
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [ssp_pkg::FUNC_W-1:0]    func_i,
  input  logic [ssp_pkg::ELEM_W-1:0]    element_i,
  input  logic [ssp_pkg::SET_W-1:0]     set_index_i,
  // result channel
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [ssp_pkg::STATUS_W-1:0]  status_i,
  input  logic                          found_i,
  input  logic [ssp_pkg::SET_W-1:0]     owner_set_i,
  input  logic [ssp_pkg::ELEM_W-1:0]    drained_element_i,
  input  logic                          drained_valid_i,
  input  logic                          last_i,
  // configuration
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [ssp_pkg::APB_AW-1:0]    paddr_i,
  input  logic [ssp_pkg::APB_DW-1:0]    pwdata_i,
  input  logic [ssp_pkg::APB_DW-1:0]    prdata_i,
  // summary
  output int unsigned                   error_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   results_checked_o
);
  import ssp_pkg::*;

  localparam logic [APB_AW-1:0] REG_ADDR = APB_AW'(4 * int'(REG_SETS_IN_USE));

  typedef struct packed {
    status_e           status;
    logic              found;
    logic [SET_W-1:0]  owner;
    logic [ELEM_W-1:0] element;
    logic              valid;
    logic              last;
  } op_result_t;

  // Shadow copy of the tables
  logic              held         [RANGE_SIZE];
  logic [SET_W-1:0]  owner_of     [RANGE_SIZE];
  logic [POS_W-1:0]  slot_of      [RANGE_SIZE];
  logic [ELEM_W-1:0] members      [NUM_SETS][SET_CAPACITY];
  int unsigned       member_count [NUM_SETS];
  logic [CFG_W-1:0]  sets_in_use;

  op_result_t due_results [$];
  op_result_t want;

  task automatic report_mismatch(input string what);
    error_count_o++;
    if (error_count_o <= 100) $display("%0t: mismatch: %s", $time, what);
  endtask

  // Work out the results of one operation and update the shadow tables
  task automatic apply_op(input func_e op, input logic [ELEM_W-1:0] elem,
                          input logic [SET_W-1:0] sidx);
    op_result_t        r;
    int unsigned       active, own, slot, tail, total, k, s, i;
    logic [ELEM_W-1:0] moved;
    active = (sets_in_use > NUM_SETS) ? NUM_SETS : sets_in_use;
    r = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    case (op)
      FUNC_ADD: begin
        // a full set needs the whole universe, so any further add is a repeat
        if (elem >= RANGE_SIZE) r.status = ST_ABSENT;
        else if (sidx >= active) r.status = ST_BAD_SET;
        else if (held[elem]) r.status = ST_PRESENT;
        else if (member_count[sidx] >= SET_CAPACITY) r.status = ST_FULL;
        else begin
          members[sidx][member_count[sidx]] = elem;
          held[elem] = 1'b1;
          owner_of[elem] = sidx;
          slot_of[elem] = POS_W'(member_count[sidx]);
          member_count[sidx]++;
        end
        due_results.push_back(r);
      end
      FUNC_REMOVE: begin
        if (elem >= RANGE_SIZE || !held[elem]) r.status = ST_ABSENT;
        else begin
          own = owner_of[elem];
          slot = slot_of[elem];
          tail = member_count[own] - 1;
          member_count[own] = tail;
          held[elem] = 1'b0;
          // fill the hole with the set's last member
          if (slot != tail) begin
            moved = members[own][tail];
            members[own][slot] = moved;
            slot_of[moved] = POS_W'(slot);
          end
        end
        due_results.push_back(r);
      end
      FUNC_QUERY: begin
        if (elem >= RANGE_SIZE || !held[elem]) r.status = ST_ABSENT;
        else begin
          r.found = 1'b1;
          r.owner = owner_of[elem];
        end
        due_results.push_back(r);
      end
      default: begin
        total = 0;
        for (s = sidx; s < active; s++) total += member_count[s];
        if (total == 0) due_results.push_back(r);
        else begin
          k = 0;
          for (s = sidx; s < active; s++) begin
            for (i = 0; i < member_count[s]; i++) begin
              k++;
              r = '0;
              r.status = ST_OK;
              r.element = members[s][i];
              r.valid = 1'b1;
              r.last = (k == total);
              held[members[s][i]] = 1'b0;
              due_results.push_back(r);
            end
            member_count[s] = 0;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < RANGE_SIZE; e++) held[e] = 1'b0;
      for (int s = 0; s < NUM_SETS; s++) member_count[s] = 0;
      sets_in_use = SETS_IN_USE_RST;
      due_results.delete();
      error_count_o = 0;
      pending_o = 0;
      results_checked_o = 0;
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == REG_ADDR) begin
        if (pwrite_i) sets_in_use = pwdata_i[CFG_W-1:0];
        else if (prdata_i !== APB_DW'(sets_in_use))
          report_mismatch($sformatf("sets_in_use read %0d, expected %0d",
                                    prdata_i, sets_in_use));
      end
      // check the result transfer before predicting a new operation
      if (out_valid_i && !out_stall_i) begin
        results_checked_o++;
        if (due_results.size() == 0)
          report_mismatch("result transfer with nothing expected");
        else begin
          want = due_results.pop_front();
          if (status_i !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      results_checked_o, status_i, want.status));
          if (found_i !== want.found)
            report_mismatch($sformatf("result %0d found %0d, expected %0d",
                                      results_checked_o, found_i, want.found));
          if (owner_set_i !== want.owner)
            report_mismatch($sformatf("result %0d owner_set %0d, expected %0d",
                                      results_checked_o, owner_set_i, want.owner));
          if (drained_element_i !== want.element)
            report_mismatch($sformatf("result %0d drained_element %0d, expected %0d",
                                      results_checked_o, drained_element_i,
                                      want.element));
          if (drained_valid_i !== want.valid)
            report_mismatch($sformatf("result %0d drained_valid %0d, expected %0d",
                                      results_checked_o, drained_valid_i, want.valid));
          if (last_i !== want.last)
            report_mismatch($sformatf("result %0d last %0d, expected %0d",
                                      results_checked_o, last_i, want.last));
        end
      end
      if (in_valid_i && !in_stall_i) apply_op(func_e'(func_i), element_i, set_index_i);
      pending_o = due_results.size();
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for sparse_set_partition_table_top
// Drives directed and random add, remove, query and drain operations under
// several set-count settings with random idling on both channels; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import ssp_pkg::*;

  // slowest legal run stays far below this
  localparam int unsigned LIMIT = 4000000;
  localparam logic [APB_AW-1:0] REG_ADDR = APB_AW'(4 * int'(REG_SETS_IN_USE));

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   in_func = '0;
  logic [ELEM_W-1:0]   in_element = '0;
  logic [SET_W-1:0]    in_set = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [SET_W-1:0]    owner_set;
  logic [ELEM_W-1:0]   drained_element;
  logic                drained_valid;
  logic                last;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int unsigned error_count, pending, results_checked;
  int unsigned op_count [4] = '{0, 0, 0, 0};
  int unsigned setting_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          steady = 1'b0;

  always #5 clk = ~clk;

  sparse_set_partition_table_top i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .func_i            (in_func),
    .element_i         (in_element),
    .set_index_i       (in_set),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .status_o          (status),
    .found_o           (found),
    .owner_set_o       (owner_set),
    .drained_element_o (drained_element),
    .drained_valid_o   (drained_valid),
    .last_o            (last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  ssp_result_checker i_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .func_i            (in_func),
    .element_i         (in_element),
    .set_index_i       (in_set),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .status_i          (status),
    .found_i           (found),
    .owner_set_i       (owner_set),
    .drained_element_i (drained_element),
    .drained_valid_i   (drained_valid),
    .last_i            (last),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .pready_i          (pready),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .prdata_i          (prdata),
    .error_count_o     (error_count),
    .pending_o         (pending),
    .results_checked_o (results_checked)
  );

  // Mostly no gap or a short one, now and then a long one; none while steady is set
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (steady) return 0;
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // One operation transfer, after an optional idle gap
  task automatic send_op(input func_e op, input logic [ELEM_W-1:0] elem,
                         input logic [SET_W-1:0] sidx);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= op;
    in_element <= elem;
    in_set <= sidx;
    do @(posedge clk); while (in_stall);
    op_count[op]++;
  endtask

  // Hold the sender until every expected result has been transferred
  task automatic wait_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_sets_in_use(input logic [CFG_W-1:0] value);
    wait_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_ADDR;
    pwdata <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // read back, the checker compares prdata
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    setting_count++;
  endtask

  // Put the whole universe into set 0, shuffle it a little, then drain it
  task automatic fill_and_drain();
    int unsigned start, k;
    write_sets_in_use(CFG_W'(8));
    start = $urandom_range(63);
    for (k = 0; k < RANGE_SIZE_DEF; k++)
      send_op(FUNC_ADD, ELEM_W'(start + k), '0);
    send_op(FUNC_ADD, ELEM_W'(start), SET_W'(1));
    for (k = 0; k < 4; k++) send_op(FUNC_REMOVE, ELEM_W'($urandom), '0);
    send_op(FUNC_QUERY, ELEM_W'($urandom), '0);
    send_op(FUNC_DRAIN, '0, '0);
  endtask

  // Random operations on a narrow element window so that they collide often
  task automatic run_phase(input int unsigned n_ops, input logic [CFG_W-1:0] setting,
                           input bit quiet);
    int unsigned roll, base, span, i;
    logic [ELEM_W-1:0] elem;
    logic [SET_W-1:0]  sidx;
    func_e             op;
    write_sets_in_use(setting);
    steady = quiet;
    base = $urandom_range(48);
    span = (setting > NUM_SETS_DEF) ? NUM_SETS_DEF : setting;
    for (i = 0; i < n_ops; i++) begin
      roll = $urandom_range(99);
      if (roll < 45) op = FUNC_ADD;
      else if (roll < 70) op = FUNC_REMOVE;
      else if (roll < 90) op = FUNC_QUERY;
      else op = FUNC_DRAIN;
      if ($urandom_range(3) == 0) elem = ELEM_W'($urandom);
      else elem = ELEM_W'(base + $urandom_range(15));
      if (span > 0 && $urandom_range(3) != 0) sidx = SET_W'($urandom_range(span - 1));
      else sidx = SET_W'($urandom);
      send_op(op, elem, sidx);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_sets_in_use(CFG_W'(8));
    send_op(FUNC_QUERY, '0, '0);          // empty table
    send_op(FUNC_REMOVE, 6'd63, 3'd7);
    send_op(FUNC_DRAIN, '0, '0);          // nothing to drain
    send_op(FUNC_ADD, '0, '0);
    send_op(FUNC_ADD, 6'd63, 3'd7);
    send_op(FUNC_ADD, '0, 3'd3);          // already held
    send_op(FUNC_ADD, 6'd5, '0);
    send_op(FUNC_ADD, 6'd9, '0);
    send_op(FUNC_QUERY, 6'd63, '0);
    send_op(FUNC_REMOVE, '0, '0);         // tail member moves into the hole
    send_op(FUNC_REMOVE, 6'd5, '0);       // last member, no move
    send_op(FUNC_REMOVE, 6'd9, '0);
    send_op(FUNC_REMOVE, 6'd9, '0);       // not held
    send_op(FUNC_ADD, 6'd42, 3'd7);
    send_op(FUNC_DRAIN, '0, 3'd7);
    send_op(FUNC_DRAIN, '0, 3'd5);
    write_sets_in_use(CFG_W'(0));         // no active set
    send_op(FUNC_ADD, 6'd1, '0);
    send_op(FUNC_DRAIN, '0, '0);
    write_sets_in_use(CFG_W'(15));        // saturates to all sets
    send_op(FUNC_ADD, 6'd1, 3'd7);
    send_op(FUNC_ADD, 6'd2, 3'd6);
    write_sets_in_use(CFG_W'(1));         // sets 6 and 7 stay populated
    send_op(FUNC_ADD, 6'd3, 3'd3);
    send_op(FUNC_QUERY, 6'd1, '0);
    send_op(FUNC_DRAIN, '0, '0);
    send_op(FUNC_REMOVE, 6'd1, '0);
    send_op(FUNC_DRAIN, '0, 3'd6);

    fill_and_drain();

    run_phase(27, CFG_W'(8), 1'b1);
    run_phase(27, CFG_W'(3), 1'b0);
    run_phase(27, CFG_W'(1), 1'b0);
    run_phase(27, CFG_W'(0), 1'b0);
    run_phase(27, CFG_W'(15), 1'b0);
    run_phase(27, CFG_W'(5), 1'b1);
    run_phase(27, CFG_W'(8), 1'b0);

    wait_results();
    repeat (20) @(posedge clk);

    $display("Covered %0d operations: %0d add, %0d remove, %0d query, %0d drain",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[FUNC_ADD], op_count[FUNC_REMOVE], op_count[FUNC_QUERY],
             op_count[FUNC_DRAIN]);
    $display("%0d results checked across %0d set-count settings",
             results_checked, setting_count);
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sparse_set_partition_table_top.f */
rtl/ssp_pkg.sv
rtl/ssp_ram.sv
rtl/sparse_set_partition_table.sv
bench/ssp_result_checker.sv
bench/tb.sv
